[design/kwm_pkg.sv]
`timescale 1ns / 1ps
// kwm_pkg: shared types and constants for the k-way merge block.
// No dependencies; imported by the interfaces, controller, datapath and top level.
package kwm_pkg;

  localparam int STREAM_W = 4;
  localparam int CFG_W    = 5;
  localparam int KEY_W    = 32;
  localparam int TAG_W    = 32;
  localparam int SEQ_W    = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic eval;
    logic scan_clear;
    logic scan_issue;
    logic load_rec;
    logic load_done;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_range;
    logic ready_all;
    logic all_ended;
    logic any_valid;
    logic done_reported;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

[design/kwm_in_if.sv]
`timescale 1ns / 1ps
// kwm_in_if: input channel carrying one stream record or end mark per item.
// Depends on kwm_pkg for field widths.
interface kwm_in_if;
  import kwm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STREAM_W-1:0] stream_index;
  logic                is_end;
  logic [KEY_W-1:0]    mass_key;
  logic [TAG_W-1:0]    record_tag;

  modport source (output valid, output stream_index, output is_end, output mass_key,
                  output record_tag, input ready);
  modport sink   (input valid, input stream_index, input is_end, input mass_key,
                  input record_tag, output ready);
endinterface

[design/kwm_out_if.sv]
`timescale 1ns / 1ps
// kwm_out_if: output channel carrying one merged record or the all-done item.
// Depends on kwm_pkg for field widths.
interface kwm_out_if;
  import kwm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STREAM_W-1:0] out_stream;
  logic [KEY_W-1:0]    out_key;
  logic [TAG_W-1:0]    out_tag;
  logic [SEQ_W-1:0]    sequence_id;
  logic                all_done;

  modport source (output valid, output out_stream, output out_key, output out_tag,
                  output sequence_id, output all_done, input ready);
  modport sink   (input valid, input out_stream, input out_key, input out_tag,
                  input sequence_id, input all_done, output ready);
endinterface

[design/kwm_ctrl.sv]
`timescale 1ns / 1ps
// kwm_ctrl: merge sequencer; accept, evaluate, scan heads, emit a record or the all-done item.
// Depends on kwm_pkg for state, command and status types.
module kwm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  kwm_pkg::stat_t st,
  output kwm_pkg::cmd_t  cmd
);
  import kwm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (st.in_valid && st.in_range) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (st.ready_all && st.any_valid) state_next = ST_SCAN;
        else if (st.all_ended && !st.any_valid && !st.done_reported) state_next = ST_DONE;
        else state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (st.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      ST_DONE: begin
        if (st.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:  cmd.in_ready = 1'b1;
      ST_EVAL: begin
        cmd.eval       = 1'b1;
        cmd.scan_clear = 1'b1;
      end
      ST_SCAN:  cmd.scan_issue = 1'b1;
      ST_DRAIN: cmd = '0;
      ST_EMIT:  cmd.load_rec  = st.out_free;
      ST_DONE:  cmd.load_done = st.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

[design/kwm_dp.sv]
`timescale 1ns / 1ps
// kwm_dp: head memory, per-stream flags, minimum scan and output register.
// Depends on kwm_pkg, kwm_in_if and kwm_out_if.
module kwm_dp #(
  parameter int MAX_STREAMS = 16,
  parameter int KEY_BITS    = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [kwm_pkg::CFG_W-1:0] cfg_wdata,
  kwm_in_if.sink                    rec_in,
  kwm_out_if.source                 rec_out,
  input  kwm_pkg::cmd_t             cmd,
  output kwm_pkg::stat_t            st
);
  import kwm_pkg::*;

  localparam int IW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int CW = $clog2(MAX_STREAMS + 1);
  localparam int XW = (CW > CFG_W) ? CW : CFG_W;
  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

  logic [CFG_W-1:0]       streams_in_use;
  logic [MAX_STREAMS-1:0] head_valid;
  logic [MAX_STREAMS-1:0] stream_ended;
  logic [MAX_STREAMS-1:0] use_mask;
  logic                   done_reported;
  logic [SEQ_W-1:0]       next_sequence;

  logic [KW+TAG_W-1:0]    head_mem [MAX_STREAMS];
  logic [KW+TAG_W-1:0]    rd_data;
  logic [KW-1:0]          rd_key;
  logic [TAG_W-1:0]       rd_tag;

  logic [IW-1:0]          scan_idx;
  logic [IW-1:0]          cmp_idx;
  logic                   cmp_en;
  logic                   cmp_hit;
  logic                   found;
  logic [IW-1:0]          best_idx;
  logic [KW-1:0]          best_key;
  logic [TAG_W-1:0]       best_tag;
  logic [XW-1:0]          best_x;

  logic [XW-1:0]          cfg_x;
  logic [XW-1:0]          max_x;
  logic [XW-1:0]          n_x;
  logic [XW-1:0]          s_x;
  logic [IW-1:0]          s_idx;
  logic                   take;
  logic                   wr_en;

  logic                   out_valid;

  assign cfg_x = XW'(streams_in_use);
  assign max_x = XW'(MAX_STREAMS);
  assign s_x   = XW'(rec_in.stream_index);
  assign s_idx = s_x[IW-1:0];

  always_comb begin
    if (cfg_x == '0) n_x = XW'(1);
    else if (cfg_x > max_x) n_x = max_x;
    else n_x = cfg_x;
  end

  always_comb begin
    for (int i = 0; i < MAX_STREAMS; i++) begin
      use_mask[i] = (XW'(i) < n_x);
    end
  end

  assign take  = rec_in.valid && cmd.in_ready;
  assign wr_en = take && st.in_range && !rec_in.is_end && !stream_ended[s_idx];

  assign rd_key  = rd_data[KW+TAG_W-1:TAG_W];
  assign rd_tag  = rd_data[TAG_W-1:0];
  assign cmp_hit = cmp_en && head_valid[cmp_idx] && (!found || (rd_key < best_key));
  assign best_x  = XW'(best_idx);

  assign rec_in.ready  = cmd.in_ready;
  assign rec_out.valid = out_valid;

  assign st.in_valid      = rec_in.valid;
  assign st.in_range      = (s_x < n_x);
  assign st.ready_all     = &(head_valid | stream_ended | ~use_mask);
  assign st.all_ended     = &(stream_ended | ~use_mask);
  assign st.any_valid     = |(head_valid & use_mask);
  assign st.done_reported = done_reported;
  assign st.scan_last     = (XW'(scan_idx) == (n_x - XW'(1)));
  assign st.out_free      = !out_valid || rec_out.ready;

  always_ff @(posedge clk) begin
    if (wr_en) head_mem[s_idx] <= {KW'(rec_in.mass_key), rec_in.record_tag};
    rd_data <= head_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      streams_in_use <= CFG_W'(1);
      head_valid     <= '0;
      stream_ended   <= '0;
      done_reported  <= 1'b0;
      next_sequence  <= '0;
      out_valid      <= 1'b0;
      scan_idx       <= '0;
      cmp_en         <= 1'b0;
      found          <= 1'b0;
    end else begin
      if (cfg_we) streams_in_use <= cfg_wdata;
      if (take && st.in_range) begin
        if (rec_in.is_end) stream_ended[s_idx] <= 1'b1;
        else if (!stream_ended[s_idx]) head_valid[s_idx] <= 1'b1;
      end
      if (cmd.eval && !st.all_ended) done_reported <= 1'b0;
      cmp_en <= cmd.scan_issue;
      if (cmd.scan_clear) begin
        scan_idx <= '0;
        found    <= 1'b0;
      end else begin
        if (cmd.scan_issue) scan_idx <= scan_idx + IW'(1);
        if (cmp_hit) found <= 1'b1;
      end
      if (cmd.load_rec || cmd.load_done) out_valid <= 1'b1;
      else if (out_valid && rec_out.ready) out_valid <= 1'b0;
      if (cmd.load_rec) begin
        head_valid[best_idx] <= 1'b0;
        next_sequence        <= next_sequence + SEQ_W'(1);
      end
      if (cmd.load_done) begin
        done_reported <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (cmp_hit) begin
      best_idx <= cmp_idx;
      best_key <= rd_key;
      best_tag <= rd_tag;
    end
    if (cmd.load_rec) begin
      rec_out.out_stream  <= best_x[STREAM_W-1:0];
      rec_out.out_key     <= KEY_W'(best_key);
      rec_out.out_tag     <= best_tag;
      rec_out.sequence_id <= next_sequence;
      rec_out.all_done    <= 1'b0;
    end
    if (cmd.load_done) begin
      rec_out.out_stream  <= '0;
      rec_out.out_key     <= '0;
      rec_out.out_tag     <= '0;
      rec_out.sequence_id <= next_sequence;
      rec_out.all_done    <= 1'b1;
    end
  end

endmodule

[design/kway_merge_by_key.sv]
`timescale 1ns / 1ps
// kway_merge_by_key: top level of the k-way merge; controller plus datapath.
// Depends on kwm_pkg, kwm_in_if, kwm_out_if, kwm_ctrl and kwm_dp.
//
//   channel   direction  handshake      payload
//   rec_in    in         valid/ready    stream_index, is_end, mass_key, record_tag
//   rec_out   out        valid/ready    out_stream, out_key, out_tag, sequence_id, all_done
//   cfg       in         cfg_we only    cfg_wdata = streams_in_use
//
// An item for a stream out of use is taken and dropped. An item that emits a record
// passes accept, evaluate, n scan reads of the head memory's single read port (n the
// streams in use), a compare drain and a load of the output register; an all-done item
// passes accept, evaluate and a load of the output register. Reset is synchronous; the
// per-stream flags are flip-flops, so no clearing pass follows reset. A result waits in
// the output register while the next item is taken; emit stalls until it is free.
module kway_merge_by_key #(
  parameter int MAX_STREAMS = 16,
  parameter int KEY_BITS    = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [kwm_pkg::CFG_W-1:0] cfg_wdata,
  kwm_in_if.sink                    rec_in,
  kwm_out_if.source                 rec_out
);
  import kwm_pkg::*;

  cmd_t  cmd;
  stat_t st;

  kwm_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  kwm_dp #(
    .MAX_STREAMS (MAX_STREAMS),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rec_in    (rec_in),
    .rec_out   (rec_out),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

[design/kwm_checker.sv]
`timescale 1ns / 1ps
// kwm_checker: port-level assertions for kway_merge_by_key, attached by bind.
// Depends on kwm_pkg for field widths.
module kwm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [kwm_pkg::STREAM_W-1:0] out_stream,
  input logic [kwm_pkg::KEY_W-1:0]    out_key,
  input logic [kwm_pkg::TAG_W-1:0]    out_tag,
  input logic [kwm_pkg::SEQ_W-1:0]    sequence_id,
  input logic                         all_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_key) && $stable(out_tag) &&
      $stable(sequence_id) && $stable(out_stream) && $stable(all_done))
    else $error("result changed while stalled");

  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && all_done |-> out_stream == '0 && out_key == '0 && out_tag == '0)
    else $error("all-done item carries a record");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after an item");

endmodule

bind kway_merge_by_key kwm_checker u_kwm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (rec_in.valid),
  .in_ready    (rec_in.ready),
  .out_valid   (rec_out.valid),
  .out_ready   (rec_out.ready),
  .out_stream  (rec_out.out_stream),
  .out_key     (rec_out.out_key),
  .out_tag     (rec_out.out_tag),
  .sequence_id (rec_out.sequence_id),
  .all_done    (rec_out.all_done)
);
